/* hw/rtl/pbba_pkg.sv */
// Shared types, codes and saturating helpers for the bounding box accumulator.
`timescale 1ns / 1ps
`default_nettype none
package pbba_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned ME_W = 31;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned IN_DW = 5 * QW;
  localparam int unsigned OUT_DW = 6 * QW;

  localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  // axis slots
  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;
  localparam int unsigned AX_Z = 2;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_PTYPE   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DCOORD  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DWIDTH  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DHEIGHT = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MINEXT  = 3'd4;

  // primitive types
  localparam logic [3:0] PT_POINT     = 4'd0;
  localparam logic [3:0] PT_RECT_XY   = 4'd1;
  localparam logic [3:0] PT_RECT_XZ   = 4'd2;
  localparam logic [3:0] PT_RECT_YZ   = 4'd3;
  localparam logic [3:0] PT_FIXDIM_XY = 4'd4;
  localparam logic [3:0] PT_FIXC_XY   = 4'd5;
  localparam logic [3:0] PT_FIXC_XZ   = 4'd6;
  localparam logic [3:0] PT_FIXC_YZ   = 4'd7;
  localparam logic [3:0] PT_FIXCD_XY  = 4'd8;
  localparam logic [3:0] PT_FIXCD_XZ  = 4'd9;
  localparam logic [3:0] PT_FIXCD_YZ  = 4'd10;
  localparam logic [3:0] PT_LINE_XZ   = 4'd11;
  localparam logic [3:0] PT_LINE_XY   = 4'd12;
  localparam logic [3:0] PT_HEXAGON   = 4'd13;

  // per-axis lower/upper values
  typedef struct packed {
    logic [2:0][QW-1:0] lo;
    logic [2:0][QW-1:0] hi;
  } span_t;

  function automatic logic [QW-1:0] sat33(input logic [QW:0] s);
    logic [QW-1:0] r;
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic [QW-1:0] add_sat(input logic [QW-1:0] x, input logic [QW-1:0] y);
    logic [QW:0] s;
    s = {x[QW-1], x} + {y[QW-1], y};
    return sat33(s);
  endfunction

  function automatic logic [QW-1:0] sub_sat(input logic [QW-1:0] x, input logic [QW-1:0] y);
    logic [QW:0] s;
    s = {x[QW-1], x} - {y[QW-1], y};
    return sat33(s);
  endfunction

  function automatic logic [QW-1:0] smin(input logic [QW-1:0] x, input logic [QW-1:0] y);
    return ($signed(x) < $signed(y)) ? x : y;
  endfunction

  function automatic logic [QW-1:0] smax(input logic [QW-1:0] x, input logic [QW-1:0] y);
    return ($signed(x) > $signed(y)) ? x : y;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/pbba_prim.sv */
// Per-primitive candidate bounds on each axis, selected by primitive type.
`timescale 1ns / 1ps
`default_nettype none
module pbba_prim import pbba_pkg::*; (
  input  logic [3:0]    ptype,
  input  logic [QW-1:0] dcoord,
  input  logic [QW-1:0] dwidth,
  input  logic [QW-1:0] dheight,
  input  logic [QW-1:0] coord_a,
  input  logic [QW-1:0] coord_b,
  input  logic [QW-1:0] coord_c,
  input  logic [QW-1:0] size_w,
  input  logic [QW-1:0] size_h,
  output span_t         cand
);

  logic [QW-1:0] apw, bph, adw, bdh, amw, bmw, bpw;

  assign apw = add_sat(coord_a, size_w);
  assign bph = add_sat(coord_b, size_h);
  assign adw = add_sat(coord_a, dwidth);
  assign bdh = add_sat(coord_b, dheight);
  assign amw = sub_sat(coord_a, size_w);
  assign bmw = sub_sat(coord_b, size_w);
  assign bpw = add_sat(coord_b, size_w);

  always_comb begin
    cand = '0;
    case (ptype)
      PT_POINT: begin
        cand.lo[AX_X] = coord_a; cand.hi[AX_X] = coord_a;
        cand.lo[AX_Y] = coord_b; cand.hi[AX_Y] = coord_b;
        cand.lo[AX_Z] = coord_c; cand.hi[AX_Z] = coord_c;
      end
      PT_RECT_XY, PT_FIXC_XY: begin
        cand.lo[AX_X] = coord_a; cand.hi[AX_X] = apw;
        cand.lo[AX_Y] = coord_b; cand.hi[AX_Y] = bph;
        cand.lo[AX_Z] = (ptype == PT_FIXC_XY) ? dcoord : coord_c;
        cand.hi[AX_Z] = cand.lo[AX_Z];
      end
      PT_RECT_XZ, PT_FIXC_XZ: begin
        cand.lo[AX_X] = coord_a; cand.hi[AX_X] = apw;
        cand.lo[AX_Z] = coord_b; cand.hi[AX_Z] = bph;
        cand.lo[AX_Y] = (ptype == PT_FIXC_XZ) ? dcoord : coord_c;
        cand.hi[AX_Y] = cand.lo[AX_Y];
      end
      PT_RECT_YZ, PT_FIXC_YZ: begin
        cand.lo[AX_Y] = coord_a; cand.hi[AX_Y] = apw;
        cand.lo[AX_Z] = coord_b; cand.hi[AX_Z] = bph;
        cand.lo[AX_X] = (ptype == PT_FIXC_YZ) ? dcoord : coord_c;
        cand.hi[AX_X] = cand.lo[AX_X];
      end
      PT_FIXDIM_XY, PT_FIXCD_XY: begin
        cand.lo[AX_X] = coord_a; cand.hi[AX_X] = adw;
        cand.lo[AX_Y] = coord_b; cand.hi[AX_Y] = bdh;
        cand.lo[AX_Z] = (ptype == PT_FIXCD_XY) ? dcoord : coord_c;
        cand.hi[AX_Z] = cand.lo[AX_Z];
      end
      PT_FIXCD_XZ: begin
        cand.lo[AX_X] = coord_a; cand.hi[AX_X] = adw;
        cand.lo[AX_Z] = coord_b; cand.hi[AX_Z] = bdh;
        cand.lo[AX_Y] = dcoord;  cand.hi[AX_Y] = dcoord;
      end
      PT_FIXCD_YZ: begin
        cand.lo[AX_Y] = coord_a; cand.hi[AX_Y] = adw;
        cand.lo[AX_Z] = coord_b; cand.hi[AX_Z] = bdh;
        cand.lo[AX_X] = dcoord;  cand.hi[AX_X] = dcoord;
      end
      PT_LINE_XZ: begin
        cand.lo[AX_X] = smin(coord_a, apw); cand.hi[AX_X] = smax(coord_a, apw);
        cand.lo[AX_Y] = dcoord;             cand.hi[AX_Y] = dcoord;
        cand.lo[AX_Z] = smin(coord_b, bph); cand.hi[AX_Z] = smax(coord_b, bph);
      end
      PT_LINE_XY: begin
        cand.lo[AX_X] = smin(coord_a, apw); cand.hi[AX_X] = smax(coord_a, apw);
        cand.lo[AX_Y] = smin(coord_b, bph); cand.hi[AX_Y] = smax(coord_b, bph);
        cand.lo[AX_Z] = dcoord;             cand.hi[AX_Z] = dcoord;
      end
      PT_HEXAGON: begin
        cand.lo[AX_X] = smin(amw, apw);     cand.hi[AX_X] = smax(amw, apw);
        cand.lo[AX_Y] = smin(bmw, bpw);     cand.hi[AX_Y] = smax(bmw, bpw);
        cand.lo[AX_Z] = coord_c;            cand.hi[AX_Z] = coord_c;
      end
      default: begin
        cand = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/pbba_widen.sv */
// Reported box: minimum extent widening per axis, zeros while the set is empty.
`timescale 1ns / 1ps
`default_nettype none
module pbba_widen import pbba_pkg::*; (
  input  span_t           bounds,
  input  logic            any_seen,
  input  logic [ME_W-1:0] min_extent,
  output span_t           box
);

  function automatic logic [QW-1:0] sat34(input logic [QW+1:0] v);
    logic [QW-1:0] r;
    if ((v[QW+1:QW-1] != 3'b000) && (v[QW+1:QW-1] != 3'b111)) begin
      r = v[QW+1] ? Q_MIN : Q_MAX;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  logic [QW+1:0] me_x;
  assign me_x = {3'b000, min_extent};

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [QW:0]   diff;
    logic [QW:0]   sum;
    logic [QW+1:0] t_lo;
    logic [QW+1:0] t_hi;
    logic          narrow;

    assign diff   = {bounds.hi[i][QW-1], bounds.hi[i]} - {bounds.lo[i][QW-1], bounds.lo[i]};
    assign sum    = {bounds.hi[i][QW-1], bounds.hi[i]} + {bounds.lo[i][QW-1], bounds.lo[i]};
    assign narrow = $signed({diff[QW], diff}) < $signed(me_x);
    // floor((s-m)/2) and floor((s+m)/2); the latter equals floor((s-m)/2)+m
    assign t_lo   = {sum[QW], sum} - me_x;
    assign t_hi   = {sum[QW], sum} + me_x;

    always_comb begin
      if (!any_seen) begin
        box.lo[i] = '0;
        box.hi[i] = '0;
      end else if (narrow) begin
        box.lo[i] = sat34({t_lo[QW+1], t_lo[QW+1:1]});
        box.hi[i] = sat34({t_hi[QW+1], t_hi[QW+1:1]});
      end else begin
        box.lo[i] = bounds.lo[i];
        box.hi[i] = bounds.hi[i];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/primitive_bounding_box_accumulator.sv */
// Top level: 3D bounding box accumulator over a stream of planar primitives.
//
//   channel  dir  payload                                      handshake
//   in_      in   tdata {a,b,c,w,h}, tuser {start,has_prim}    tvalid/tready
//   out_     out  tdata {xmin,xmax,ymin,ymax,zmin,zmax},       tvalid/tready
//                 tuser {bad_type}
//   cfg_     in   addr = register index, wdata                 we, no wait
//
// One word per cycle sustained while out_tready holds; from input accept to result
// valid a word passes input reg at accept, then candidate reg, bounds update, result reg.
// The bounds registers fold one word per cycle while stage 3 has room, compare and select only.
// Reset (sync, rst_n low) empties the box and loads register defaults.
// Each stage holds its word when the next one is full and stalled; input keeps accepting
// while the stages ahead have room.
`timescale 1ns / 1ps
`default_nettype none
module primitive_bounding_box_accumulator import pbba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // coord_a, coord_b, coord_c, size_w, size_h
  input  logic [1:0]        in_tuser,   // start_set, has_primitive
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // x_min, x_max, y_min, y_max, z_min, z_max
  output logic [0:0]        out_tuser,  // bad_type
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [QW-1:0]     cfg_wdata
);

  // configuration
  logic [3:0]      ptype_r;
  logic [QW-1:0]   dcoord_r, dwidth_r, dheight_r;
  logic [ME_W-1:0] min_ext_r;

  // pipeline control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s2_rdy, s3_rdy, out_rdy;

  // stage 1
  logic [IN_DW-1:0] s1_data_r;
  logic [1:0]       s1_user_r;

  // stage 2
  span_t cand;
  span_t cand_r;
  logic  s2_fold_r, s2_start_r, s2_bad_r;
  logic  bad;

  // box state
  span_t bounds_r, bounds_nxt, base;
  logic  any_seen_r, any_seen_nxt;
  logic  s3_bad_r;

  // result
  span_t box;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_bad_r;

  assign out_rdy   = !out_v_r || out_tready;
  assign s3_rdy    = !s3_v_r || out_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign in_tready = !s1_v_r || s2_rdy;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

  assign bad = (ptype_r > PT_HEXAGON);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptype_r   <= PT_RECT_XY;
      dcoord_r  <= '0;
      dwidth_r  <= 32'h0001_0000;
      dheight_r <= 32'h0001_0000;
      min_ext_r <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PTYPE:   ptype_r   <= cfg_wdata[3:0];
        CFG_DCOORD:  dcoord_r  <= cfg_wdata;
        CFG_DWIDTH:  dwidth_r  <= cfg_wdata;
        CFG_DHEIGHT: dheight_r <= cfg_wdata;
        CFG_MINEXT:  min_ext_r <= cfg_wdata[ME_W-1:0];
        default: ;
      endcase
    end
  end

  pbba_prim u_prim (
    .ptype   (ptype_r),
    .dcoord  (dcoord_r),
    .dwidth  (dwidth_r),
    .dheight (dheight_r),
    .coord_a (s1_data_r[0*QW +: QW]),
    .coord_b (s1_data_r[1*QW +: QW]),
    .coord_c (s1_data_r[2*QW +: QW]),
    .size_w  (s1_data_r[3*QW +: QW]),
    .size_h  (s1_data_r[4*QW +: QW]),
    .cand    (cand)
  );

  always_comb begin
    base         = bounds_r;
    any_seen_nxt = any_seen_r;
    if (s2_start_r) begin
      for (int i = 0; i < 3; i++) begin
        base.lo[i] = Q_MAX;
        base.hi[i] = Q_MIN;
      end
      any_seen_nxt = 1'b0;
    end
    bounds_nxt = base;
    if (s2_fold_r) begin
      for (int i = 0; i < 3; i++) begin
        bounds_nxt.lo[i] = smin(base.lo[i], cand_r.lo[i]);
        bounds_nxt.hi[i] = smax(base.hi[i], cand_r.hi[i]);
      end
      any_seen_nxt = 1'b1;
    end
  end

  // bounds_r only moves when a word enters stage 3, so it matches that word
  pbba_widen u_widen (
    .bounds     (bounds_r),
    .any_seen   (any_seen_r),
    .min_extent (min_ext_r),
    .box        (box)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      any_seen_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bounds_r.lo[i] <= Q_MAX;
        bounds_r.hi[i] <= Q_MIN;
      end
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s3_v_r;
      end
      if (s3_rdy && s2_v_r) begin
        bounds_r   <= bounds_nxt;
        any_seen_r <= any_seen_nxt;
      end
    end

    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
    if (s2_rdy && s1_v_r) begin
      cand_r     <= cand;
      s2_start_r <= s1_user_r[0];
      s2_fold_r  <= s1_user_r[1] && !bad;
      s2_bad_r   <= bad;
    end
    if (s3_rdy && s2_v_r) begin
      s3_bad_r <= s2_bad_r;
    end
    if (out_rdy && s3_v_r) begin
      out_data_r <= {box.hi[AX_Z], box.lo[AX_Z], box.hi[AX_Y], box.lo[AX_Y],
                     box.hi[AX_X], box.lo[AX_X]};
      out_bad_r  <= s3_bad_r;
    end
  end

endmodule
`default_nettype wire
